// ===== hdl/string_repr_escaper_assert.svh =====
// Assertion macros used by the checker file of the escaper.
`ifndef STRING_REPR_ESCAPER_ASSERT_SVH
`define STRING_REPR_ESCAPER_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define SRE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sre_pkg.sv =====
// Types, character codes and helpers shared by the escaper modules.
`default_nettype none
package sre_pkg;

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_NONE  = 2'd3
  } sre_cmd_t;

  localparam int MaxOut = 6;
  localparam int CntW   = $clog2(MaxOut + 1);
  localparam int IdxW   = $clog2(MaxOut);
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_A_LOWER  = 8'h61;

  // One emit item worked out: the output bytes in order and how many.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
    logic                   close;
  } sre_desc_t;

  // Queue status seen by the front end and back end.
  typedef struct packed {
    logic full;
    logic empty;
  } sre_qstat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {4'd0, nib};
    end else begin
      hex_char = CH_A_LOWER + {4'd0, nib} - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/string_repr_escaper.sv =====
// An emit transfer is queued when taken; its bytes leave once earlier items have drained.
// Throughput: one input transfer per cycle while the two-entry queue has room; the
//   one-byte output port then drains 1 to 6 bytes per emit item.
// Scan and unused commands produce nothing.
// Reset (rst, synchronous) clears the quote flags, queue and output byte index.
`default_nettype none
module string_repr_escaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic       run_last,
  output      logic       text_end
);
  import sre_pkg::*;

  sre_desc_t  desc;
  sre_desc_t  head;
  sre_qstat_t qstat;
  logic       push;
  logic       pop;

  sre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .qstat      (qstat),
    .push       (push),
    .desc       (desc)
  );

  sre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  sre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
  );

endmodule
`default_nettype wire

// ===== hdl/sre_front.sv =====
// Front end: takes input transfers, tracks quote flags, builds output descriptors.
`default_nettype none
module sre_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first_byte,
  input  wire logic              last_byte,
  input  wire sre_pkg::sre_qstat_t qstat,
  output      logic              push,
  output      sre_pkg::sre_desc_t desc
);
  import sre_pkg::*;

  logic            seen_single_quote, seen_single_quote_next;
  logic            seen_double_quote, seen_double_quote_next;
  sre_cmd_t        cmd_code;
  logic            accept;
  logic [7:0]      quote;
  logic [3:0][7:0] esc;
  logic [CntW-1:0] elen;
  logic [CntW-1:0] off;

  assign cmd_code = sre_cmd_t'(cmd);
  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (cmd_code == CMD_EMIT || cmd_code == CMD_EMPTY);
  assign quote    = (seen_single_quote && !seen_double_quote) ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    seen_single_quote_next = (first_byte ? 1'b0 : seen_single_quote)
                             | (data_byte == CH_SQUOTE);
    seen_double_quote_next = (first_byte ? 1'b0 : seen_double_quote)
                             | (data_byte == CH_DQUOTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_single_quote <= 1'b0;
      seen_double_quote <= 1'b0;
    end else if (accept && cmd_code == CMD_SCAN) begin
      seen_single_quote <= seen_single_quote_next;
      seen_double_quote <= seen_double_quote_next;
    end
  end

  // escape sequence for the data byte alone
  always_comb begin
    esc    = '0;
    esc[0] = CH_BSLASH;
    elen   = CntW'(2);
    if (data_byte == quote || data_byte == CH_BSLASH) begin
      esc[1] = data_byte;
    end else if (data_byte == CH_TAB) begin
      esc[1] = CH_T;
    end else if (data_byte == CH_CR) begin
      esc[1] = CH_R;
    end else if (data_byte == CH_LF) begin
      esc[1] = CH_N;
    end else if (data_byte >= CH_PRINT_LO && data_byte < CH_DEL) begin
      esc[0] = data_byte;
      elen   = CntW'(1);
    end else begin
      esc[1] = CH_X;
      esc[2] = hex_char(data_byte[7:4]);
      esc[3] = hex_char(data_byte[3:0]);
      elen   = CntW'(4);
    end
  end

  always_comb begin
    desc = '0;
    off  = first_byte ? CntW'(1) : CntW'(0);
    if (cmd_code == CMD_EMPTY) begin
      desc.bytes[0] = CH_SQUOTE;
      desc.bytes[1] = CH_SQUOTE;
      desc.count    = CntW'(2);
      desc.close    = 1'b1;
    end else begin
      if (first_byte) begin
        desc.bytes[0] = quote;
      end
      for (int k = 0; k < 4; k++) begin
        if (CntW'(k) < elen) begin
          desc.bytes[IdxW'(off + CntW'(k))] = esc[k];
        end
      end
      if (last_byte) begin
        desc.bytes[IdxW'(off + elen)] = quote;
      end
      desc.count = off + elen + (last_byte ? CntW'(1) : CntW'(0));
      desc.close = last_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sre_queue.sv =====
// Short descriptor queue between front end and back end.
`default_nettype none
module sre_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sre_pkg::sre_desc_t push_desc,
  input  wire logic               pop,
  output      sre_pkg::sre_desc_t head,
  output      sre_pkg::sre_qstat_t qstat
);
  import sre_pkg::*;

  sre_desc_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] fill;

  assign qstat.full  = (fill == QCntW'(QDepth));
  assign qstat.empty = (fill == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCntW'(1);
      end else if (pop && !push) begin
        fill <= fill - QCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sre_back.sv =====
// Back end: plays out the head descriptor one byte per output transfer.
`default_nettype none
module sre_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sre_pkg::sre_desc_t  head,
  input  wire sre_pkg::sre_qstat_t qstat,
  output      logic                pop,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [7:0]          out_byte,
  output      logic                run_last,
  output      logic                text_end
);
  import sre_pkg::*;

  logic [IdxW-1:0] idx;
  logic            at_last;

  assign out_valid = !qstat.empty;
  assign at_last   = (CntW'(idx) == head.count - CntW'(1));
  assign out_byte  = head.bytes[idx];
  assign run_last  = at_last;
  assign text_end  = at_last && head.close;
  assign pop       = out_valid && out_ready && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= at_last ? '0 : idx + IdxW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sre_checker.sv =====
// Port-level checks for the escaper, bound to the top level.
`default_nettype none
`include "string_repr_escaper_assert.svh"
module sre_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       run_last,
  input wire logic       text_end
);
  import sre_pkg::*;

  `SRE_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "output valid right after reset")

  `SRE_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> in_ready, "input not ready right after reset")

  `SRE_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte), "stalled output changed")

  `SRE_ASSERT(a_end_is_last, clk, rst, out_valid && text_end |-> run_last, "text end not last of its run")

  `SRE_ASSERT(a_end_is_quote, clk, rst, out_valid && text_end |-> out_byte == CH_DQUOTE || out_byte == CH_SQUOTE, "text end byte is not a quote")

endmodule

bind string_repr_escaper sre_checker u_sre_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the string_repr_escaper quoting and escaping block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sre_pkg::*;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned CycleLimit  = 500000;

  // One byte of escaped text as it should leave the block.
  typedef struct packed {
    logic [7:0] text;
    logic       last_of_item;
    logic       closes;
  } out_char_t;

  class escape_scoreboard;
    out_char_t   pending_chars[$];
    bit          saw_single;
    bit          saw_double;
    int unsigned errors;
    string       hex_digits = "0123456789abcdef";

    function int unsigned pending();
      return pending_chars.size();
    endfunction

    function void add_char(logic [7:0] b, logic closes);
      out_char_t c;
      c.text = b;
      c.last_of_item = 1'b0;
      c.closes = closes;
      pending_chars.push_back(c);
    endfunction

    // Works out the output bytes of one accepted input transfer.
    function void note_input(sre_cmd_t c, logic [7:0] d, logic f, logic l);
      int unsigned start_size;
      logic [7:0]  q;
      start_size = pending_chars.size();
      case (c)
        CMD_SCAN: begin
          if (f) begin
            saw_single = 1'b0;
            saw_double = 1'b0;
          end
          if (d == CH_SQUOTE) saw_single = 1'b1;
          if (d == CH_DQUOTE) saw_double = 1'b1;
        end
        CMD_EMIT: begin
          q = (saw_single && !saw_double) ? CH_DQUOTE : CH_SQUOTE;
          if (f) add_char(q, 1'b0);
          if (d == q || d == CH_BSLASH) begin
            add_char(CH_BSLASH, 1'b0);
            add_char(d, 1'b0);
          end else if (d == CH_TAB) begin
            add_char(CH_BSLASH, 1'b0);
            add_char(CH_T, 1'b0);
          end else if (d == CH_CR) begin
            add_char(CH_BSLASH, 1'b0);
            add_char(CH_R, 1'b0);
          end else if (d == CH_LF) begin
            add_char(CH_BSLASH, 1'b0);
            add_char(CH_N, 1'b0);
          end else if (d >= CH_PRINT_LO && d < CH_DEL) begin
            add_char(d, 1'b0);
          end else begin
            add_char(CH_BSLASH, 1'b0);
            add_char(CH_X, 1'b0);
            add_char(hex_digits[d[7:4]], 1'b0);
            add_char(hex_digits[d[3:0]], 1'b0);
          end
          if (l) add_char(q, 1'b1);
        end
        CMD_EMPTY: begin
          add_char(CH_SQUOTE, 1'b0);
          add_char(CH_SQUOTE, 1'b1);
        end
        default: ;
      endcase
      if (pending_chars.size() > start_size)
        pending_chars[pending_chars.size() - 1].last_of_item = 1'b1;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [7:0] b, logic rl, logic te);
      out_char_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("byte %02h run_last %b text_end %b with nothing pending", b, rl, te));
        return;
      end
      want = pending_chars.pop_front();
      if (b !== want.text || rl !== want.last_of_item || te !== want.closes)
        report($sformatf("expected byte %02h run_last %b text_end %b, got %02h %b %b",
                         want.text, want.last_of_item, want.closes, b, rl, te));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = 2'b00;
  logic [7:0] data_byte = 8'h00;
  logic       first_byte = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  escape_scoreboard sb;
  int unsigned      burst_left;
  int unsigned      items_sent;
  int unsigned      cycle_count;
  logic [7:0]       text_buf[$];

  string_repr_escaper dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .text_end   (text_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Handshake signals only move at the rising edge, so the falling edge sees
  // exactly what the next rising edge will take.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(sre_cmd_t'(cmd), data_byte, first_byte, last_byte);
      if (out_valid && out_ready)
        sb.check_result(out_byte, run_last, text_end);
    end
  end

  // Receiver back-pressure: always ready, coin flip, fixed pattern, or long stalls.
  int unsigned rx_mode;
  int unsigned rx_count;
  int unsigned rx_run;
  logic        rx_hold = 1'b1;
  always @(posedge clk) begin
    rx_count++;
    if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_count % 3) != 0;
      default: begin
        if (rx_run == 0) begin
          rx_run = $urandom_range(1, 8);
          rx_hold = !rx_hold;
        end
        rx_run--;
        out_ready <= rx_hold;
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("string_repr_escaper regression: fail");
      $finish;
    end
  end

  // Presents one item and returns at the edge where it is transferred.
  task automatic push_item(input sre_cmd_t c, input logic [7:0] d, input logic f,
                           input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid   <= 1'b1;
    cmd        <= c;
    data_byte  <= d;
    first_byte <= f;
    last_byte  <= l;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (c != CMD_NONE) items_sent++;
  endtask

  // Always moves on at least one edge so valid is never assigned twice in a step.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_char(int unsigned quote_mix);
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      4: ch = CH_SQUOTE;
      5: ch = CH_DQUOTE;
      6: ch = CH_BSLASH;
      7: begin
        case ($urandom_range(0, 2))
          0: ch = CH_TAB;
          1: ch = CH_CR;
          default: ch = CH_LF;
        endcase
      end
      8: begin
        case ($urandom_range(0, 6))
          0: ch = 8'h00;
          1: ch = 8'h1f;
          2: ch = CH_PRINT_LO;
          3: ch = 8'h7e;
          4: ch = CH_DEL;
          5: ch = 8'h80;
          default: ch = 8'hff;
        endcase
      end
      9: ch = 8'($urandom_range(32, 126));
      default: ch = 8'($urandom_range(0, 255));
    endcase
    // quote_mix bit 0 allows single quotes, bit 1 allows double quotes
    if (ch == CH_SQUOTE && !quote_mix[0]) ch = CH_A_LOWER;
    if (ch == CH_DQUOTE && !quote_mix[1]) ch = CH_A_LOWER;
    return ch;
  endfunction

  task automatic make_text();
    int unsigned len;
    int unsigned quote_mix;
    text_buf.delete();
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    quote_mix = $urandom_range(0, 3);
    repeat (len) text_buf.push_back(pick_char(quote_mix));
  endtask

  // broken: first/last markers are random instead of framing the pass
  task automatic send_pass(input sre_cmd_t c, input bit broken);
    logic f;
    logic l;
    for (int i = 0; i < text_buf.size(); i++) begin
      f = (i == 0);
      l = (i == text_buf.size() - 1);
      if (broken) begin
        f = 1'($urandom_range(0, 1));
        l = 1'($urandom_range(0, 1));
      end
      push_item(c, text_buf[i], f, l);
    end
  endtask

  task automatic run_directed();
    // emitting straight after reset uses single quotes
    push_item(CMD_EMIT, CH_A_LOWER, 1'b1, 1'b0);
    push_item(CMD_EMIT, CH_SQUOTE, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_DQUOTE, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_BSLASH, 1'b0, 1'b1);
    drain_outputs();
    push_item(CMD_EMPTY, 8'hff, 1'b1, 1'b1);
    push_item(CMD_NONE, CH_SQUOTE, 1'b1, 1'b1);
    drain_outputs();
    // single quote only: text goes in double quotes
    push_item(CMD_SCAN, CH_X, 1'b1, 1'b0);
    push_item(CMD_SCAN, CH_SQUOTE, 1'b0, 1'b1);
    push_item(CMD_EMIT, CH_X, 1'b1, 1'b0);
    push_item(CMD_EMIT, CH_SQUOTE, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_DQUOTE, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_TAB, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_CR, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_LF, 1'b0, 1'b0);
    push_item(CMD_EMIT, 8'h00, 1'b0, 1'b0);
    push_item(CMD_EMIT, 8'h1f, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_PRINT_LO, 1'b0, 1'b0);
    push_item(CMD_EMIT, 8'h7e, 1'b0, 1'b0);
    push_item(CMD_EMIT, CH_DEL, 1'b0, 1'b0);
    push_item(CMD_EMIT, 8'h80, 1'b0, 1'b0);
    push_item(CMD_EMIT, 8'hff, 1'b0, 1'b1);
    drain_outputs();
    // fresh scan clears the flags; one-byte text gives the longest run
    push_item(CMD_SCAN, CH_DQUOTE, 1'b1, 1'b1);
    push_item(CMD_EMIT, 8'hff, 1'b1, 1'b1);
  endtask

  task automatic run_random();
    int unsigned pick;
    int unsigned iter;
    iter = 0;
    while (items_sent < RandomItems + 24) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        make_text();
        send_pass(CMD_SCAN, 1'b0);
        send_pass(CMD_EMIT, 1'b0);
      end else if (pick < 16) begin
        push_item(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        push_item(sre_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        make_text();
        send_pass(sre_cmd_t'($urandom_range(0, 1)), 1'b1);
      end
      iter++;
      if (iter % 37 == 36) drain_outputs();
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain_outputs();
    run_random();
    drain_outputs();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("string_repr_escaper regression: pass");
    end else begin
      $display("string_repr_escaper regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
